### rtl/core/wc8_pkg.sv
package wc8_pkg;

	// depth of the queue between front and back, a power of two
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [31:0] CP_MAX     = 32'h0010_FFFF;
	localparam logic [21:0] HIGH_TAG   = 22'h36;  // 0xd800 >> 10
	localparam logic [21:0] LOW_TAG    = 22'h37;  // 0xdc00 >> 10
	localparam logic [20:0] SUPP_BASE  = 21'h01_0000;
	localparam logic [5:0]  SURR_TOP   = 6'b110110;

	// length codes, number of bytes minus one
	localparam logic [1:0] LEN_1 = 2'd0;
	localparam logic [1:0] LEN_2 = 2'd1;
	localparam logic [1:0] LEN_3 = 2'd2;
	localparam logic [1:0] LEN_4 = 2'd3;

	// one classified unit, as the back end carries it out
	typedef struct packed {
		logic        err;        // out-of-range unit, one error result
		logic        last;       // unit closed the string
		logic        held_v;     // a lone high surrogate goes out first
		logic [9:0]  held_bits;
		logic        cp_v;       // a code point follows
		logic [20:0] cp;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

### rtl/core/wc8_front.sv
module wc8_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [31:0]        code_unit,
	input  logic               last_unit,
	input  wc8_pkg::q_stat_t   q_stat,
	output logic               push,
	output wc8_pkg::job_t      push_job
);
	import wc8_pkg::*;

	logic       join_pairs_q;
	logic       held_q;
	logic [9:0] held_bits_q;
	logic       discard_q;

	logic [31:0] u;
	logic        take;
	logic        is_high;
	logic        is_low;
	logic        out_of_range;
	logic        held_nxt;
	logic        discard_nxt;

	assign in_ready = !q_stat.full;
	assign take     = in_valid && in_ready;

	assign u            = join_pairs_q ? {16'h0000, code_unit[15:0]} : code_unit;
	assign is_high      = (u[31:10] == HIGH_TAG);
	assign is_low       = (u[31:10] == LOW_TAG);
	assign out_of_range = (u > CP_MAX);

	always_comb begin
		push_job           = '0;
		push_job.last      = last_unit;
		push_job.held_bits = held_bits_q;
		held_nxt           = held_q;
		discard_nxt        = discard_q;
		push               = 1'b0;
		if (take) begin
			if (discard_q) begin
				// swallow the rest of a failed string
				if (last_unit) begin
					discard_nxt = 1'b0;
				end
			end else if (out_of_range) begin
				push_job.err = 1'b1;
				push         = 1'b1;
				held_nxt     = 1'b0;
				discard_nxt  = !last_unit;
			end else if (held_q && is_low) begin
				push_job.cp_v = 1'b1;
				push_job.cp   = SUPP_BASE + 21'({held_bits_q, u[9:0]});
				push          = 1'b1;
				held_nxt      = 1'b0;
			end else begin
				push_job.held_v = held_q;
				if (join_pairs_q && is_high && !last_unit) begin
					held_nxt = 1'b1;
				end else begin
					push_job.cp_v = 1'b1;
					push_job.cp   = u[20:0];
					held_nxt      = 1'b0;
				end
				push = held_q || push_job.cp_v;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			join_pairs_q <= 1'b0;
			held_q       <= 1'b0;
			discard_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				join_pairs_q <= cfg_data;
			end
			held_q    <= held_nxt;
			discard_q <= discard_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (take && is_high) begin
			held_bits_q <= u[9:0];
		end
	end

endmodule

### rtl/core/wc8_fifo.sv
module wc8_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  wc8_pkg::job_t      push_job,
	input  logic               pop,
	output wc8_pkg::job_t      head,
	output wc8_pkg::q_stat_t   q_stat
);
	import wc8_pkg::*;

	job_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign head         = entry_q[rd_ptr_q];
	assign q_stat.full  = (count_q == (QPTR_W+1)'(QDEPTH));
	assign q_stat.empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

### rtl/core/wc8_back.sv
module wc8_back #(
	parameter int MAX_UNITS = 1048576
) (
	input  logic               clk,
	input  logic               arst_n,
	input  wc8_pkg::job_t      head,
	input  wc8_pkg::q_stat_t   q_stat,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_byte,
	output logic               last_of_char,
	output logic               last_of_run,
	output logic               end_of_string,
	output logic               error_flag,
	output logic [22:0]        byte_total,
	output logic [20:0]        char_total
);
	import wc8_pkg::*;

	localparam longint BYTE_CAP_L = (64'(MAX_UNITS) * 64'd4 < 64'h7F_FFFF) ?
		64'(MAX_UNITS) * 64'd4 : 64'h7F_FFFF;
	localparam longint CHAR_CAP_L = (64'(MAX_UNITS) < 64'h1F_FFFF) ?
		64'(MAX_UNITS) : 64'h1F_FFFF;
	localparam logic [22:0] BYTE_CAP = 23'(BYTE_CAP_L);
	localparam logic [20:0] CHAR_CAP = 21'(CHAR_CAP_L);

	logic        held_done_q;
	logic [1:0]  k_q;
	logic [22:0] bytes_q;
	logic [20:0] chars_q;

	logic        step;
	logic        in_held;
	logic [20:0] cp_cur;
	logic [1:0]  len_m1;
	logic [1:0]  rem;
	logic [20:0] cp_shift;
	logic [7:0]  byte_v;
	logic        char_end;
	logic        run_end;
	logic [22:0] bytes_inc;
	logic [20:0] chars_inc;

	assign step    = !q_stat.empty && (!out_valid || out_ready);
	assign in_held = head.held_v && !held_done_q;
	assign cp_cur  = in_held ? {5'b00000, SURR_TOP, head.held_bits} : head.cp;

	always_comb begin
		if (in_held || cp_cur >= 21'h00_0800) begin
			len_m1 = (in_held || cp_cur < SUPP_BASE) ? LEN_3 : LEN_4;
		end else begin
			len_m1 = (cp_cur < 21'h00_0080) ? LEN_1 : LEN_2;
		end
	end

	assign rem      = len_m1 - k_q;
	assign cp_shift = cp_cur >> (5'd6 * {3'b000, rem});
	assign char_end = (k_q == len_m1);
	assign run_end  = head.err || (char_end && (!in_held || !head.cp_v));

	always_comb begin
		if (k_q != 2'd0) begin
			byte_v = {2'b10, cp_shift[5:0]};
		end else begin
			unique case (len_m1)
				LEN_1:   byte_v = {1'b0, cp_cur[6:0]};
				LEN_2:   byte_v = {3'b110, cp_cur[10:6]};
				LEN_3:   byte_v = {4'b1110, cp_cur[15:12]};
				LEN_4:   byte_v = {5'b11110, cp_cur[20:18]};
				default: byte_v = 8'h00;
			endcase
		end
	end

	assign bytes_inc = (bytes_q < BYTE_CAP) ? bytes_q + 23'd1 : bytes_q;
	assign chars_inc = (char_end && chars_q < CHAR_CAP) ? chars_q + 21'd1 : chars_q;

	assign pop = step && run_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid   <= 1'b0;
			held_done_q <= 1'b0;
			k_q         <= '0;
			bytes_q     <= '0;
			chars_q     <= '0;
		end else begin
			if (step) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (step) begin
				if (head.err) begin
					// nothing more comes out of this string, so the totals restart here
					bytes_q <= '0;
					chars_q <= '0;
				end else begin
					if (run_end && head.last) begin
						bytes_q <= '0;
						chars_q <= '0;
					end else begin
						bytes_q <= bytes_inc;
						chars_q <= chars_inc;
					end
				end
				if (run_end) begin
					held_done_q <= 1'b0;
					k_q         <= '0;
				end else if (char_end) begin
					held_done_q <= 1'b1;
					k_q         <= '0;
				end else begin
					k_q <= k_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			last_of_run   <= run_end;
			end_of_string <= run_end && head.last;
			error_flag    <= head.err;
			if (head.err) begin
				out_byte     <= 8'h00;
				last_of_char <= 1'b0;
				byte_total   <= bytes_q;
				char_total   <= chars_q;
			end else begin
				out_byte     <= byte_v;
				last_of_char <= char_end;
				byte_total   <= bytes_inc;
				char_total   <= chars_inc;
			end
		end
	end

endmodule

### rtl/core/wide_char_to_utf8_transcoder.sv
// wide character to utf-8 transcoder. each input transaction carries one code unit and a
// last-of-string mark; each output transaction carries one utf-8 byte with its framing marks
// and the running byte and character totals of the string. join_pairs set: units are 16 bits,
// a high surrogate followed by a low one becomes one four-byte code point, any unpaired
// surrogate goes out on its own as three bytes. join_pairs clear: 32-bit units, each encoded
// singly. a unit above 0x10ffff yields one error transaction and the rest of that string is
// swallowed. the front end takes one unit per cycle while the two-entry queue has room; the
// back end emits one byte per cycle while the output is ready; a unit makes 0 to 7 bytes
// (typically 1 to 3; an error makes one error transaction), and the output port sets the
// sustained rate. no clearing pass after reset; write join_pairs only while idle.
module wide_char_to_utf8_transcoder #(
	parameter int MAX_UNITS = 1048576
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	// input code units
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] code_unit,
	input  logic        last_unit,
	// output bytes
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        last_of_char,
	output logic        last_of_run,
	output logic        end_of_string,
	output logic        error_flag,
	output logic [22:0] byte_total,
	output logic [20:0] char_total
);
	import wc8_pkg::*;

	job_t    push_job;
	job_t    head;
	q_stat_t q_stat;
	logic    push;
	logic    pop;

	// the register takes a write in any cycle
	assign cfg_ready = 1'b1;

	// front: surrogate pairing, range check and the discard state of a failed string
	wc8_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.code_unit (code_unit),
		.last_unit (last_unit),
		.q_stat    (q_stat),
		.push      (push),
		.push_job  (push_job)
	);

	// queue of classified units, only units that make at least one output transaction get in
	wc8_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	// back: byte sequencer, saturating totals and the output register
	wc8_back #(
		.MAX_UNITS (MAX_UNITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.q_stat        (q_stat),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.last_of_char  (last_of_char),
		.last_of_run   (last_of_run),
		.end_of_string (end_of_string),
		.error_flag    (error_flag),
		.byte_total    (byte_total),
		.char_total    (char_total)
	);

endmodule

### dv/wc8_stream_checker.sv
`timescale 1ns / 100ps

module wc8_stream_checker #(
	parameter int MAX_UNITS = 1048576
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] code_unit,
	input  logic        last_unit,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  out_byte,
	input  logic        last_of_char,
	input  logic        last_of_run,
	input  logic        end_of_string,
	input  logic        error_flag,
	input  logic [22:0] byte_total,
	input  logic [20:0] char_total,
	output int          mismatches,
	output int          outstanding,
	output int          bytes_checked
);

	localparam longint BYTE_CAP = (4 * longint'(MAX_UNITS) < 64'h7F_FFFF) ?
		4 * longint'(MAX_UNITS) : 64'h7F_FFFF;
	localparam longint CHAR_CAP = (longint'(MAX_UNITS) < 64'h1F_FFFF) ?
		longint'(MAX_UNITS) : 64'h1F_FFFF;

	localparam logic [31:0] CP_LIMIT   = 32'h0010_FFFF;
	localparam logic [31:0] HIGH_FIRST = 32'h0000_D800;
	localparam logic [31:0] HIGH_LAST  = 32'h0000_DBFF;
	localparam logic [31:0] LOW_FIRST  = 32'h0000_DC00;
	localparam logic [31:0] LOW_LAST   = 32'h0000_DFFF;

	typedef struct {
		logic [7:0]  data;
		logic        char_end;
		logic        run_end;
		logic        str_end;
		logic        err;
		logic [22:0] bytes;
		logic [20:0] chars;
	} utf8_beat_t;

	logic       pairing;
	logic       hi_held;
	logic [9:0] hi_bits;
	logic       swallowing;
	longint     byte_count;
	longint     char_count;
	utf8_beat_t beats_due[$];
	utf8_beat_t unit_beats[$];

	task automatic emit_byte(input logic [7:0] b, input logic char_end);
		utf8_beat_t beat;
		if (byte_count < BYTE_CAP)
			byte_count++;
		if (char_end && char_count < CHAR_CAP)
			char_count++;
		beat = '{data: b, char_end: char_end, run_end: 1'b0, str_end: 1'b0, err: 1'b0,
			bytes: byte_count[22:0], chars: char_count[20:0]};
		unit_beats.push_back(beat);
	endtask

	task automatic encode_point(input logic [20:0] cp);
		if (cp < 21'h80) begin
			emit_byte(cp[7:0], 1'b1);
		end else if (cp < 21'h800) begin
			emit_byte({3'b110, cp[10:6]}, 1'b0);
			emit_byte({2'b10, cp[5:0]}, 1'b1);
		end else if (cp < 21'h1_0000) begin
			emit_byte({4'b1110, cp[15:12]}, 1'b0);
			emit_byte({2'b10, cp[11:6]}, 1'b0);
			emit_byte({2'b10, cp[5:0]}, 1'b1);
		end else begin
			emit_byte({5'b11110, cp[20:18]}, 1'b0);
			emit_byte({2'b10, cp[17:12]}, 1'b0);
			emit_byte({2'b10, cp[11:6]}, 1'b0);
			emit_byte({2'b10, cp[5:0]}, 1'b1);
		end
	endtask

	task automatic close_string();
		byte_count = 0;
		char_count = 0;
		hi_held    = 1'b0;
		hi_bits    = '0;
		swallowing = 1'b0;
	endtask

	// works out the bytes one accepted unit gives rise to
	task automatic predict_unit(input logic [31:0] raw, input logic last);
		logic [31:0] u;
		logic [20:0] cp;
		utf8_beat_t  beat;
		unit_beats.delete();
		if (swallowing) begin
			if (last)
				close_string();
		end else begin
			u = pairing ? {16'h0000, raw[15:0]} : raw;
			if (u > CP_LIMIT) begin
				beat = '{data: 8'h00, char_end: 1'b0, run_end: 1'b1, str_end: last, err: 1'b1,
					bytes: byte_count[22:0], chars: char_count[20:0]};
				unit_beats.push_back(beat);
				hi_held = 1'b0;
				hi_bits = '0;
				if (last)
					close_string();
				else
					swallowing = 1'b1;
			end else begin
				if (hi_held && u >= LOW_FIRST && u <= LOW_LAST) begin
					cp = 21'h1_0000 + {1'b0, hi_bits, u[9:0]};
					hi_held = 1'b0;
					hi_bits = '0;
					encode_point(cp);
				end else begin
					if (hi_held) begin
						encode_point({5'b00000, 6'b110110, hi_bits});
						hi_held = 1'b0;
						hi_bits = '0;
					end
					if (pairing && u >= HIGH_FIRST && u <= HIGH_LAST && !last) begin
						hi_bits = u[9:0];
						hi_held = 1'b1;
					end else begin
						encode_point(u[20:0]);
					end
				end
				if (unit_beats.size() > 0) begin
					beat = unit_beats.pop_back();
					beat.run_end = 1'b1;
					beat.str_end = last;
					unit_beats.push_back(beat);
				end
				if (last)
					close_string();
			end
		end
		foreach (unit_beats[i])
			beats_due.push_back(unit_beats[i]);
	endtask

	function automatic int check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		int         bad;
		utf8_beat_t want;
		if (!arst_n) begin
			pairing = 1'b0;
			close_string();
			beats_due.delete();
			mismatches    <= 0;
			outstanding   <= 0;
			bytes_checked <= 0;
		end else begin
			bad = 0;
			if (cfg_valid && cfg_ready)
				pairing = cfg_data;
			if (in_valid && in_ready)
				predict_unit(code_unit, last_unit);
			if (out_valid && out_ready) begin
				if (beats_due.size() == 0) begin
					$error("output transaction 0x%0h with nothing expected", out_byte);
					bad = 1;
				end else begin
					want = beats_due.pop_front();
					bad += check_field("out_byte", want.data, out_byte);
					bad += check_field("last_of_char", want.char_end, last_of_char);
					bad += check_field("last_of_run", want.run_end, last_of_run);
					bad += check_field("end_of_string", want.str_end, end_of_string);
					bad += check_field("error_flag", want.err, error_flag);
					bad += check_field("byte_total", want.bytes, byte_total);
					bad += check_field("char_total", want.chars, char_total);
				end
				bytes_checked <= bytes_checked + 1;
			end
			mismatches  <= mismatches + bad;
			outstanding <= beats_due.size();
		end
	end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps

module tb;

	localparam int     MAX_UNITS       = 1048576;
	localparam int     HOLD_OFF_CYCLES = 160;  // long receiver stall, fills the unit queue
	localparam int     SETTLE_CYCLES   = 12;   // covers units that make no byte at all
	localparam int     UNIT_GOAL       = 270;
	localparam int     PHASE_UNITS     = 40;
	localparam longint TIMEOUT_NS      = 5_000_000;

	localparam logic [31:0] HIGH_BASE = 32'h0000_D800;
	localparam logic [31:0] LOW_BASE  = 32'h0000_DC00;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data  = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [31:0] code_unit = '0;
	logic        last_unit = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        last_of_char;
	logic        last_of_run;
	logic        end_of_string;
	logic        error_flag;
	logic [22:0] byte_total;
	logic [20:0] char_total;

	int mismatches;
	int outstanding;
	int bytes_checked;

	// calm and the hold-off counts are shared between stimulus and sink; the rest are stimulus tallies
	bit calm            = 1'b0;  // no idling on either side while set
	int hold_offs_asked = 0;
	int hold_offs_done  = 0;
	int units_sent      = 0;
	int strings_sent    = 0;
	int phases_run      = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	wide_char_to_utf8_transcoder #(
		.MAX_UNITS(MAX_UNITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.code_unit(code_unit),
		.last_unit(last_unit),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.last_of_char(last_of_char),
		.last_of_run(last_of_run),
		.end_of_string(end_of_string),
		.error_flag(error_flag),
		.byte_total(byte_total),
		.char_total(char_total)
	);

	// watches all three channels, predicts the byte stream and scores it
	wc8_stream_checker #(
		.MAX_UNITS(MAX_UNITS)
	) utf8_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.code_unit(code_unit),
		.last_unit(last_unit),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.last_of_char(last_of_char),
		.last_of_run(last_of_run),
		.end_of_string(end_of_string),
		.error_flag(error_flag),
		.byte_total(byte_total),
		.char_total(char_total),
		.mismatches(mismatches),
		.outstanding(outstanding),
		.bytes_checked(bytes_checked)
	);

	// idle length: mostly none, often a short one, now and then a long one
	function automatic int idle_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// one input transaction; valid is only dropped when a gap is wanted, so back-to-back
	// units keep valid high and just change the payload
	task automatic send_unit(input logic [31:0] u, input logic last);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		code_unit <= u;
		last_unit <= last;
		do @(posedge clk); while (!in_ready);
		units_sent++;
	endtask

	// sender stops and waits for every expected byte, then waits out a settling pause in case
	// the last unit was swallowed or left a surrogate held
	task automatic settle_out();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_pairing(input logic v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// a scalar value of random encoded length, never a surrogate
	function automatic logic [31:0] scalar_unit(input bit bmp_only);
		int k;
		k = $urandom_range(0, bmp_only ? 2 : 3);
		case (k)
			0: return $urandom_range(0, 'h7F);
			1: return $urandom_range('h80, 'h7FF);
			2: return $urandom_range(0, 1) ? $urandom_range('h800, 'hD7FF)
				: $urandom_range('hE000, 'hFFFF);
			default: return $urandom_range('h1_0000, 'h10_FFFF);
		endcase
	endfunction

	// builds one string, mostly well-formed text with some broken surrogates and, in
	// single mode, the odd out-of-range unit that throws away the rest of the string
	task automatic send_string(input bit pairing, input int len);
		logic [31:0] units[$];
		logic [31:0] upper;
		int          k;
		while (units.size() < len) begin
			k = $urandom_range(0, 99);
			if (pairing) begin
				if (k < 35) begin
					units.push_back(scalar_unit(1'b1));
				end else if (k < 70) begin
					units.push_back(HIGH_BASE | $urandom_range(0, 'h3FF));
					units.push_back(LOW_BASE | $urandom_range(0, 'h3FF));
				end else if (k < 80) begin
					units.push_back(HIGH_BASE | $urandom_range(0, 'h3FF));
				end else if (k < 88) begin
					units.push_back(LOW_BASE | $urandom_range(0, 'h3FF));
				end else begin
					units.push_back($urandom());
				end
			end else begin
				if (k < 72) begin
					units.push_back(scalar_unit(1'b0));
				end else if (k < 82) begin
					units.push_back($urandom_range('hD800, 'hDFFF));
				end else if (k < 86) begin
					units.push_back(HIGH_BASE | $urandom_range(0, 'h3FF));
					units.push_back(LOW_BASE | $urandom_range(0, 'h3FF));
				end else if (k < 93) begin
					units.push_back($urandom_range('h11_0000, 'hFFFF_FFFF));
				end else begin
					units.push_back($urandom());
				end
			end
		end
		foreach (units[i]) begin
			// upper half is don't-care in pairing mode, so fill it with noise
			upper = pairing ? ($urandom() & 32'hFFFF_0000) : 32'h0;
			send_unit(units[i] | upper, i == units.size() - 1);
		end
		strings_sent++;
	endtask

	// output side: ready runs broken by random stalls, plus a long hold-off on request
	initial begin : sink
		int run;
		int gap;
		@(posedge clk);
		forever begin
			if (hold_offs_done != hold_offs_asked) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_offs_done++;
			end else begin
				run = $urandom_range(1, 12);
				out_ready <= 1'b1;
				repeat (run) @(posedge clk);
				gap = idle_len();
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	initial begin : stimulus
		bit pairing;
		int phase;
		int first_unit;
		int len;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single mode straight out of reset: every length boundary, surrogates on their own
		send_unit(32'h0000_0000, 1'b0);
		send_unit(32'h0000_007F, 1'b0);
		send_unit(32'h0000_0080, 1'b0);
		send_unit(32'h0000_07FF, 1'b0);
		send_unit(32'h0000_0800, 1'b0);
		send_unit(32'h0000_FFFF, 1'b0);
		send_unit(32'h0001_0000, 1'b0);
		send_unit(32'h0010_FFFF, 1'b0);
		send_unit(32'h0000_D800, 1'b0);
		send_unit(32'h0000_DFFF, 1'b1);
		// out-of-range unit mid-string, the rest is swallowed up to the last mark
		send_unit(32'h0000_0041, 1'b0);
		send_unit(32'h0011_0000, 1'b0);
		send_unit(32'h0000_0042, 1'b0);
		send_unit(32'hFFFF_FFFF, 1'b1);
		// out-of-range unit that is itself the last one
		send_unit(32'h8000_0000, 1'b1);
		settle_out();

		write_pairing(1'b1);
		pairing = 1'b1;
		// lowest and highest pairs, upper halves ignored on the first
		send_unit(32'h1234_D800, 1'b0);
		send_unit(32'hFFFF_DC00, 1'b0);
		send_unit(32'h0000_DBFF, 1'b0);
		send_unit(32'h0000_DFFF, 1'b0);
		// high followed by high, the second then pairs up
		send_unit(32'h0000_D802, 1'b0);
		send_unit(32'h0000_D803, 1'b0);
		send_unit(32'h0000_DC05, 1'b0);
		// lone low, then a high surrogate closing the string
		send_unit(32'h0000_DC00, 1'b0);
		send_unit(32'h0000_DBFF, 1'b1);

		// random phases, alternating the mode; phases 2 and 3 run with no idling and
		// phase 3 asks the sink for a long hold-off while units keep coming
		for (phase = 0; units_sent < UNIT_GOAL; phase++) begin
			// now and then leave a high surrogate held across the mode change
			if (pairing && (phase % 2) == 0 && $urandom_range(0, 1))
				send_unit(HIGH_BASE | $urandom_range(0, 'h3FF), 1'b0);
			settle_out();
			pairing = (phase % 2) == 1;
			write_pairing(pairing);
			calm = (phase == 2 || phase == 3);
			if (phase == 3)
				hold_offs_asked++;
			// a low surrogate first may complete a held high one from the last phase
			if (!pairing && $urandom_range(0, 1))
				send_unit(LOW_BASE | $urandom_range(0, 'h3FF), 1'b0);
			first_unit = units_sent;
			while (units_sent - first_unit < PHASE_UNITS) begin
				len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 20);
				send_string(pairing, len);
			end
			phases_run++;
		end
		calm = 1'b0;
		settle_out();

		$display("covered %0d code units in %0d strings over %0d random phases, both modes",
			units_sent, strings_sent, phases_run);
		$display("%0d output bytes checked, %0d long receiver hold-off(s), %0d mismatches",
			bytes_checked, hold_offs_done, mismatches);
		if (mismatches == 0 && outstanding == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// hard stop if something hangs
	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("timeout with %0d bytes still expected", outstanding);
		$display("Simulation FAILED");
		$finish;
	end

endmodule
